### src/hsd_pkg.sv
package hsd_pkg;

   localparam int MaxElementsDefault = 64;

   typedef struct packed {
      logic [63:0] value_bits;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [63:0] sorted_bits;
      logic        final_res;
      logic        overflow;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SIFT_INIT,
      ST_RD_NODE,
      ST_RD_LEFT,
      ST_RD_RIGHT,
      ST_WAIT,
      ST_DECIDE,
      ST_WR_PICK,
      ST_EXT_RD_LAST,
      ST_EXT_WAIT,
      ST_EXT_WR_ROOT,
      ST_EMIT_RD,
      ST_EMIT_WAIT,
      ST_EMIT_OUT
   } state_type;

   // IEEE less-than on bit patterns; signed zeros are equal.
   function automatic logic fp_less(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] ka;
      logic [63:0] kb;
      logic        both_zero;
      both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
      ka = a[63] ? ~a : (a | {1'b1, 63'd0});
      kb = b[63] ? ~b : (b | {1'b1, 63'd0});
      return !both_zero && (ka < kb);
   endfunction

endpackage

### src/hsd_ram.sv
module hsd_ram #(
   parameter int Width = 64,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### src/heap_sort_doubles.sv
// heap_sort_doubles collects IEEE double bit patterns, one request per cycle
// while loading, into an internal store of MAX_ELEMENTS entries, and on the
// request marked last heapsorts the set in place and emits it in ascending order,
// flagging the final response and, on every response, whether requests were
// dropped because the store was full. The sort runs on one shared comparator and
// a single-port-write, single-port-read RAM under a small sequencer. Each sift
// level reads the parent and both children through the registered read port
// (ST_RD_NODE to ST_WAIT), compares the parent with the larger child in ST_DECIDE,
// and finishes the swap in ST_WR_PICK. Each extraction swaps the root with the
// last heap entry through ST_EXT_RD_LAST, ST_EXT_WAIT and ST_EXT_WR_ROOT. Each
// response is read through ST_EMIT_RD and ST_EMIT_WAIT and waits in ST_EMIT_OUT
// while the output is stalled. The block holds req_ready low from the last
// request until the final response has been placed in the output register, so
// loading of the next set can start while that response still waits. NaN inputs
// are outside the contract.
module heap_sort_doubles #(
   parameter int MAX_ELEMENTS = hsd_pkg::MaxElementsDefault
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  hsd_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output hsd_pkg::rsp_type rsp_data
);

   import hsd_pkg::*;

   localparam int AW = $clog2(MAX_ELEMENTS);
   localparam int CW = $clog2(MAX_ELEMENTS + 1);

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          dropped_ff, dropped_in;
   // Heap bound during the sort phase; it shrinks by one per extraction.
   logic [CW-1:0] limit_ff, limit_in;
   // Next build node plus one; zero means build is done.
   logic [CW-1:0] build_ff, build_in;
   logic [CW-1:0] node_ff, node_in;
   logic [CW-1:0] emit_ff, emit_in;
   logic [63:0]   pv_ff, pv_in, lv_ff, lv_in, rv_ff, rv_in;
   logic          has_right_ff, has_right_in;
   logic          pick_right_ff, pick_right_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [63:0]   wr_data, rd_data;

   hsd_ram #(.Width(64), .Depth(MAX_ELEMENTS)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   logic [CW:0] left_idx;
   logic [CW:0] pick_idx;
   logic [63:0] pick_val;
   logic [63:0] cmp_a;
   logic [63:0] cmp_b;
   logic        cmp_less;

   always_comb begin
      left_idx = {node_ff, 1'b1};
      pick_val = pick_right_ff ? rv_ff : lv_ff;
      pick_idx = left_idx + (CW+1)'(pick_right_ff);
      // The single comparator chooses between the children while the right
      // child arrives, then compares the parent against the chosen child.
      cmp_a    = (state_ff == ST_WAIT) ? lv_ff : pv_ff;
      cmp_b    = (state_ff == ST_WAIT) ? rd_data : pick_val;
      cmp_less = fp_less(cmp_a, cmp_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      limit_ff      <= limit_in;
      build_ff      <= build_in;
      node_ff       <= node_in;
      emit_ff       <= emit_in;
      pv_ff         <= pv_in;
      lv_ff         <= lv_in;
      rv_ff         <= rv_in;
      has_right_ff  <= has_right_in;
      pick_right_ff <= pick_right_in;
      rsp_ff        <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      dropped_in    = dropped_ff;
      limit_in      = limit_ff;
      build_in      = build_ff;
      node_in       = node_ff;
      emit_in       = emit_ff;
      pv_in         = pv_ff;
      lv_in         = lv_ff;
      rv_in         = rv_ff;
      has_right_in  = has_right_ff;
      pick_right_in = pick_right_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      wr_data       = req_data.value_bits;
      rd_addr       = node_ff[AW-1:0];
      req_ready     = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (count_ff == CW'(MAX_ELEMENTS)) begin
                  dropped_in = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               if (req_data.last) begin
                  // Count after this request is stored.
                  limit_in   = count_in;
                  // Build starts at (n-2)/2, done when n < 2.
                  build_in   = (count_in < CW'(2)) ? '0 :
                               CW'(((count_in - CW'(2)) >> 1) + CW'(1));
                  state_in   = ST_SIFT_INIT;
               end
            end
         end
         ST_SIFT_INIT: begin
            if (build_ff != '0) begin
               node_in  = build_ff - 1'b1;
               build_in = build_ff - 1'b1;
               state_in = ST_RD_NODE;
            end else if (limit_ff > CW'(1)) begin
               // Swap root with last heap entry, then sift root over limit-1.
               rd_addr    = '0;
               state_in   = ST_EXT_RD_LAST;
            end else begin
               emit_in  = '0;
               state_in = (count_ff == '0) ? ST_LOAD : ST_EMIT_RD;
            end
         end
         ST_EXT_RD_LAST: begin
            pv_in    = rd_data;                 // old root
            rd_addr  = AW'(limit_ff - 1'b1);
            state_in = ST_EXT_WAIT;
         end
         ST_EXT_WAIT: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(limit_ff - 1'b1);
            wr_data  = pv_ff;
            lv_in    = rd_data;
            limit_in = limit_ff - 1'b1;
            state_in = ST_EXT_WR_ROOT;
         end
         ST_EXT_WR_ROOT: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = lv_ff;
            node_in  = '0;
            state_in = ST_RD_NODE;
         end
         ST_RD_NODE: begin
            if (left_idx < (CW+1)'(limit_ff)) begin
               rd_addr  = node_ff[AW-1:0];
               state_in = ST_RD_LEFT;
            end else begin
               state_in = ST_SIFT_INIT;
            end
         end
         ST_RD_LEFT: begin
            pv_in        = rd_data;
            rd_addr      = AW'(left_idx);
            has_right_in = (left_idx + 1'b1) < (CW+1)'(limit_ff);
            state_in     = ST_RD_RIGHT;
         end
         ST_RD_RIGHT: begin
            lv_in    = rd_data;
            rd_addr  = AW'(left_idx + 1'b1);
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            rv_in         = rd_data;
            pick_right_in = has_right_ff && cmp_less;
            state_in      = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (cmp_less) begin
               wr_en    = 1'b1;
               wr_addr  = node_ff[AW-1:0];
               wr_data  = pick_val;
               state_in = ST_WR_PICK;
            end else begin
               state_in = ST_SIFT_INIT;
            end
         end
         ST_WR_PICK: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(pick_idx);
            wr_data  = pv_ff;
            node_in  = CW'(pick_idx);
            state_in = ST_RD_NODE;
         end
         ST_EMIT_RD: begin
            rd_addr  = AW'(emit_ff);
            state_in = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            // Keep the read address so the data stays put in the next state.
            rd_addr  = AW'(emit_ff);
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            rd_addr = AW'(emit_ff);
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.sorted_bits   = rd_data;
               rsp_in.final_res     = (emit_ff + 1'b1) == count_ff;
               rsp_in.overflow      = dropped_ff;
               emit_in              = emit_ff + 1'b1;
               if ((emit_ff + 1'b1) == count_ff) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_LOAD;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ELEMENTS)) else $error("element count beyond capacity");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_in && !rsp_valid_ff && rsp_in.final_res && state_ff == ST_EMIT_OUT
      |=> count_ff == '0 && !dropped_ff) else $error("count not cleared after final");
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_LOAD |-> !req_ready) else $error("request taken while sorting");
`endif

endmodule
